// ----- src/lpd_pkg.sv -----
// shared constants and crc helper for the lidar packet deframer
package lpd_pkg;

  localparam int POINTS_DEFAULT = 12;
  localparam logic [7:0] HDR_A = 8'h54;
  localparam logic [7:0] HDR_B = 8'h2C;
  localparam logic [7:0] CRC_POLY = 8'h4D;
  localparam int FULL_TURN = 36000;
  localparam int DEG_PER_TURN = 360;

  // one byte through the msb-first crc-8
  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- src/lidar_packet_deframer.sv -----
// lidar packet deframer: header hunt, crc check, point expansion
//
// Usage: received bytes enter on in_valid/in_ready/in_rx_byte, one request per
// byte. The block hunts for the pair 0x54 0x2C, stores one packet of
// 3*POINTS_PER_PACKET+11 bytes in a packet memory and runs the crc-8 on the fly.
// A byte that completes no packet gives no result.
// A completed packet with a good crc gives POINTS_PER_PACKET point results on
// out_valid/out_ready; a bad crc gives one result with out_kind set, then the
// stored bytes after the header are replayed through the hunter from memory.
// Expansion: a good packet reads its six field bytes (speed, start and end
// angle) and divides the span by POINTS_PER_PACKET-1 with a reciprocal
// multiply; each point then fetches its three bytes from memory and is emitted.
// A bad packet loads its error request once the output register is free, then
// replays PKT_LEN-2 bytes, one per cycle through the single memory read port.
// in_ready is low unless the block is idle. A stalled receiver
// holds the output register; expansion waits on it, replay does not.
// Reset clears the hunter, counters and output valid; the packet memory is
// not cleared, since only bytes written for the current packet are read.
module lidar_packet_deframer #(
  parameter int POINTS_PER_PACKET = lpd_pkg::POINTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [15:0]        out_rotor_speed,
  output logic [3:0]         out_point_index,
  output logic [15:0]        out_distance,
  output logic [7:0]         out_confidence,
  output logic signed [17:0] out_angle_centideg,
  output logic [3:0]         out_angle_elevenths,
  output logic               out_last_point
);

  localparam int PKT_LEN = 3 * POINTS_PER_PACKET + 11;
  localparam int AW = $clog2(PKT_LEN);
  localparam int PW = $clog2(PKT_LEN + 1);
  localparam int DIV = POINTS_PER_PACKET - 1;
  localparam int RW = $clog2(POINTS_PER_PACKET);
  localparam int IW = $clog2(POINTS_PER_PACKET);
  localparam int OFFSET = lpd_pkg::FULL_TURN * DIV;
  localparam int UW = $clog2(65536 + OFFSET);
  localparam int SH = UW + $clog2(DIV);
  localparam int MW = UW + 1;
  localparam longint RECIP = ((longint'(1) << SH) + DIV - 1) / DIV;
  localparam logic [MW-1:0] RECIP_W = MW'(RECIP);
  localparam logic [UW-1:0] DIV_Q = UW'(DIV);
  localparam int SW = $clog2(UW + 8);
  localparam int QW = 19;
  localparam logic [7:0] CRC_HDR =
    lpd_pkg::crc_next(lpd_pkg::crc_next(8'h00, lpd_pkg::HDR_A), lpd_pkg::HDR_B);
  localparam logic [AW-1:0] END_ADDR = AW'(6 + 3 * POINTS_PER_PACKET);
  localparam logic signed [QW-1:0] TURN = QW'(lpd_pkg::FULL_TURN);
  localparam logic [RW:0] DIV_W = (RW + 1)'(DIV);

  // read tags: which slot the returning memory byte fills
  localparam logic [3:0] TG_SPD_LO = 4'd0;
  localparam logic [3:0] TG_SPD_HI = 4'd1;
  localparam logic [3:0] TG_STA_LO = 4'd2;
  localparam logic [3:0] TG_STA_HI = 4'd3;
  localparam logic [3:0] TG_END_LO = 4'd4;
  localparam logic [3:0] TG_END_HI = 4'd5;
  localparam logic [3:0] TG_DST_LO = 4'd6;
  localparam logic [3:0] TG_DST_HI = 4'd7;
  localparam logic [3:0] TG_CONF   = 4'd8;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_SEEN    = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ERR    = 7'b0000010,
    ST_REPLAY = 7'b0000100,
    ST_HEAD   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_PFETCH = 7'b0100000,
    ST_PEMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic rp_v_r, rp_v_nxt;
  logic [SW-1:0] seq_r, seq_nxt;

  // packet memory
  logic [7:0] mem [PKT_LEN];
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0] rdata_r;
  logic [3:0] tag_r, tag_nxt;
  logic tv_r;

  // captured packet fields
  logic [7:0] spd_lo_r, spd_hi_r, sta_lo_r, sta_hi_r, end_lo_r, end_hi_r;
  logic [7:0] dst_lo_r, dst_hi_r, conf_r;

  // divider and angle stepping
  logic [UW-1:0] dv_num_r, dv_num_nxt, dv_quo_r, dv_quo_nxt;
  logic [RW-1:0] dv_rem_r, dv_rem_nxt;
  logic signed [QW-1:0] sq_r, sq_nxt, q_r, q_nxt;
  logic [RW-1:0] sr_r, sr_nxt, r_r, r_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [AW-1:0] base_r, base_nxt;

  // output register
  logic out_valid_r, out_valid_nxt, out_load, out_err, out_free;
  logic out_kind_r, out_last_r;
  logic [15:0] out_speed_r, out_dist_r;
  logic [3:0] out_idx_r, out_elev_r;
  logic [7:0] out_conf_r;
  logic signed [17:0] out_angle_r;

  // absorb inputs and results
  logic ab_en;
  logic [7:0] ab_byte;
  logic ab_done, ab_ok;

  // span and division helpers
  logic signed [17:0] diff, span;
  logic signed [UW:0] u_s;
  logic [UW+MW-1:0] dv_prod;
  logic [UW-1:0] dv_back;
  logic [RW:0] r_sum;
  logic r_carry;
  logic wrap;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // byte source for the hunter: the input or a replayed memory byte
  always_comb begin
    ab_en = 1'b0;
    ab_byte = in_rx_byte;
    if (state_r == ST_IDLE) begin
      ab_en = in_valid;
    end else if (state_r == ST_REPLAY) begin
      ab_en = rp_v_r;
      ab_byte = rdata_r;
    end
  end

  // header hunter and packet collector
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    mem_we = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = ab_byte;
    ab_done = 1'b0;
    ab_ok = 1'b0;
    if (ab_en) begin
      unique case (phase_r)
        PH_COLLECT: begin
          if (cnt_r >= PW'(PKT_LEN)) begin
            phase_nxt = PH_SEARCH;
            cnt_nxt = '0;
          end else begin
            mem_we = 1'b1;
            if (cnt_r < PW'(PKT_LEN - 1)) begin
              crc_nxt = lpd_pkg::crc_next(crc_r, ab_byte);
              cnt_nxt = cnt_r + PW'(1);
            end else begin
              phase_nxt = PH_SEARCH;
              cnt_nxt = '0;
              ab_done = 1'b1;
              ab_ok = (crc_r == ab_byte);
            end
          end
        end
        PH_SEEN: begin
          if (ab_byte == lpd_pkg::HDR_B) begin
            cnt_nxt = PW'(2);
            crc_nxt = CRC_HDR;
            phase_nxt = PH_COLLECT;
          end else if (ab_byte != lpd_pkg::HDR_A) begin
            phase_nxt = PH_SEARCH;
          end
        end
        default: begin
          phase_nxt = (ab_byte == lpd_pkg::HDR_A) ? PH_SEEN : PH_SEARCH;
        end
      endcase
    end
  end

  // span, offset numerator and reciprocal divide
  always_comb begin
    diff = $signed({2'b00, end_hi_r, end_lo_r}) - $signed({2'b00, sta_hi_r, sta_lo_r});
    span = (diff > 18'sd0) ? diff : diff + 18'(lpd_pkg::FULL_TURN);
    u_s = (UW + 1)'(span) + (UW + 1)'(OFFSET);
    dv_prod = dv_num_r * RECIP_W;
    dv_back = UW'(dv_quo_r * DIV_Q);
    r_sum = {1'b0, r_r} + {1'b0, sr_r};
    r_carry = (r_sum >= DIV_W);
    wrap = (q_r > TURN) || ((q_r == TURN) && (r_r != '0));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rp_nxt = rp_r;
    rp_v_nxt = 1'b0;
    seq_nxt = seq_r;
    mem_re = 1'b0;
    mem_raddr = '0;
    tag_nxt = TG_SPD_LO;
    dv_num_nxt = dv_num_r;
    dv_quo_nxt = dv_quo_r;
    dv_rem_nxt = dv_rem_r;
    sq_nxt = sq_r;
    sr_nxt = sr_r;
    q_nxt = q_r;
    r_nxt = r_r;
    i_nxt = i_r;
    base_nxt = base_r;
    out_load = 1'b0;
    out_err = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (ab_done) begin
          state_nxt = ab_ok ? ST_HEAD : ST_ERR;
          seq_nxt = '0;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          out_err = 1'b1;
          state_nxt = ST_REPLAY;
          rp_nxt = PW'(2);
        end
      end
      ST_REPLAY: begin
        if (rp_r < PW'(PKT_LEN)) begin
          mem_re = 1'b1;
          mem_raddr = rp_r[AW-1:0];
          rp_v_nxt = 1'b1;
          rp_nxt = rp_r + PW'(1);
        end else if (!rp_v_r) begin
          rp_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_HEAD: begin
        seq_nxt = seq_r + SW'(1);
        case (seq_r)
          SW'(0): begin mem_re = 1'b1; mem_raddr = AW'(2); tag_nxt = TG_SPD_LO; end
          SW'(1): begin mem_re = 1'b1; mem_raddr = AW'(3); tag_nxt = TG_SPD_HI; end
          SW'(2): begin mem_re = 1'b1; mem_raddr = AW'(4); tag_nxt = TG_STA_LO; end
          SW'(3): begin mem_re = 1'b1; mem_raddr = AW'(5); tag_nxt = TG_STA_HI; end
          SW'(4): begin mem_re = 1'b1; mem_raddr = END_ADDR; tag_nxt = TG_END_LO; end
          SW'(5): begin
            mem_re = 1'b1;
            mem_raddr = END_ADDR + AW'(1);
            tag_nxt = TG_END_HI;
          end
          SW'(7): begin
            dv_num_nxt = u_s[UW-1:0];
            seq_nxt = '0;
            state_nxt = ST_DIV;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        // quotient by reciprocal multiply, then remainder by multiply back
        seq_nxt = seq_r + SW'(1);
        if (seq_r == '0) begin
          dv_quo_nxt = UW'(dv_prod >> SH);
        end else begin
          dv_rem_nxt = RW'(dv_num_r - dv_back);
          seq_nxt = '0;
          state_nxt = ST_PFETCH;
        end
      end
      ST_PFETCH: begin
        // the first fetch of the first point also settles the per-step quotient and remainder
        if (seq_r == '0 && i_r == '0) begin
          sq_nxt = QW'($signed({1'b0, dv_quo_r})) - TURN;
          sr_nxt = dv_rem_r;
          q_nxt = QW'($signed({1'b0, sta_hi_r, sta_lo_r}));
          r_nxt = '0;
        end
        seq_nxt = seq_r + SW'(1);
        case (seq_r)
          SW'(0): begin mem_re = 1'b1; mem_raddr = base_r; tag_nxt = TG_DST_LO; end
          SW'(1): begin
            mem_re = 1'b1;
            mem_raddr = base_r + AW'(1);
            tag_nxt = TG_DST_HI;
          end
          SW'(2): begin
            mem_re = 1'b1;
            mem_raddr = base_r + AW'(2);
            tag_nxt = TG_CONF;
          end
          default: state_nxt = ST_PEMIT;
        endcase
      end
      ST_PEMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          r_nxt = r_carry ? RW'(r_sum - DIV_W) : r_sum[RW-1:0];
          q_nxt = q_r + sq_r + QW'(r_carry);
          seq_nxt = '0;
          if (i_r == IW'(POINTS_PER_PACKET - 1)) begin
            i_nxt = '0;
            base_nxt = AW'(6);
            state_nxt = ST_IDLE;
          end else begin
            i_nxt = i_r + IW'(1);
            base_nxt = base_r + AW'(3);
            state_nxt = ST_PFETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SEARCH;
      cnt_r <= '0;
      crc_r <= '0;
      rp_r <= '0;
      rp_v_r <= 1'b0;
      seq_r <= '0;
      tv_r <= 1'b0;
      i_r <= '0;
      base_r <= AW'(6);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      rp_r <= rp_nxt;
      rp_v_r <= rp_v_nxt;
      seq_r <= seq_nxt;
      tv_r <= mem_re && (state_r != ST_REPLAY);
      i_r <= i_nxt;
      base_r <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // packet memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
    tag_r <= tag_nxt;
  end

  // capture returning bytes into field slots
  always_ff @(posedge clk) begin
    if (tv_r) begin
      case (tag_r)
        TG_SPD_LO: spd_lo_r <= rdata_r;
        TG_SPD_HI: spd_hi_r <= rdata_r;
        TG_STA_LO: sta_lo_r <= rdata_r;
        TG_STA_HI: sta_hi_r <= rdata_r;
        TG_END_LO: end_lo_r <= rdata_r;
        TG_END_HI: end_hi_r <= rdata_r;
        TG_DST_LO: dst_lo_r <= rdata_r;
        TG_DST_HI: dst_hi_r <= rdata_r;
        TG_CONF:   conf_r <= rdata_r;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dv_num_r <= dv_num_nxt;
    dv_quo_r <= dv_quo_nxt;
    dv_rem_r <= dv_rem_nxt;
    sq_r <= sq_nxt;
    sr_r <= sr_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  // output register load
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= out_err;
      out_last_r <= out_err || (i_r == IW'(POINTS_PER_PACKET - 1));
      if (out_err) begin
        out_speed_r <= '0;
        out_idx_r <= '0;
        out_dist_r <= '0;
        out_conf_r <= '0;
        out_angle_r <= '0;
        out_elev_r <= '0;
      end else begin
        out_speed_r <= {spd_hi_r, spd_lo_r};
        out_idx_r <= 4'(i_r);
        out_dist_r <= {dst_hi_r, dst_lo_r};
        out_conf_r <= conf_r;
        out_angle_r <= wrap ? 18'(q_r - TURN) : 18'(q_r);
        out_elev_r <= 4'(r_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_rotor_speed = out_speed_r;
  assign out_point_index = out_idx_r;
  assign out_distance = out_dist_r;
  assign out_confidence = out_conf_r;
  assign out_angle_centideg = out_angle_r;
  assign out_angle_elevenths = out_elev_r;
  assign out_last_point = out_last_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < PW'(PKT_LEN)) else $error("byte count out of range");

  a_replay_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> !ab_done) else $error("replay completed a packet");

  a_collect_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COLLECT) |-> (cnt_r >= PW'(2))) else $error("collect below header");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> out_last_r) else $error("error request not last");

endmodule
